@@ hdl/mmc_pkg.sv @@
`default_nettype none
package mmc_pkg;

  localparam int NUM_AXES = 3;
  localparam int RAW_W    = 16;
  localparam int RANGE_W  = 16;
  localparam int SUM_W    = 18;
  localparam int DVSR_W   = 19;
  localparam int REM_W    = DVSR_W + 1;
  localparam int OFS_W    = 17;
  localparam int DIFF_W   = 18;
  localparam int CAL_W    = 24;
  localparam int CNT_W    = 10;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_CALIB_SAMPLES = 1'b0;

  localparam logic [CNT_W-1:0] CALIB_SAMPLES_RST = 10'd500;
  localparam logic signed [RAW_W-1:0] MIN_RST = 16'sh7FFF;
  localparam logic signed [RAW_W-1:0] MAX_RST = 16'sh8000;

  localparam logic KIND_START  = 1'b0;
  localparam logic KIND_SAMPLE = 1'b1;

  typedef enum logic [1:0] {
    STAT_CALIB = 2'd0,
    STAT_DONE  = 2'd1,
    STAT_FAIL  = 2'd2,
    STAT_CORR  = 2'd3
  } status_t;

endpackage
`default_nettype wire

@@ hdl/mmc_div.sv @@
`default_nettype none
module mmc_div #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  input  wire logic [mmc_pkg::SUM_W+FRAC_BITS-1:0] numer,
  input  wire logic [mmc_pkg::DVSR_W-1:0]        divisor,
  output logic                                   done,
  output logic [FRAC_BITS+1:0]                   quot
);

  localparam int SW = FRAC_BITS + 2;
  localparam int NW = mmc_pkg::SUM_W + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam int RW = mmc_pkg::REM_W;

  logic                            busy_r;
  logic                            done_r;
  logic [CW-1:0]                   cnt_r;
  logic [NW-1:0]                   num_r;
  logic [mmc_pkg::DVSR_W-1:0]      dvs_r;
  logic [RW-1:0]                   rem_r;
  logic [SW-1:0]                   quo_r;
  logic                            ovf_r;

  logic [RW-1:0] trial;
  logic          ge;
  logic [RW-1:0] rem_nxt;

  // restoring division, one quotient bit a cycle, msb first
  always_comb begin
    trial   = {rem_r[RW-2:0], num_r[NW-1]};
    ge      = (trial >= {1'b0, dvs_r});
    rem_nxt = ge ? (trial - {1'b0, dvs_r}) : trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        num_r  <= numer;
        dvs_r  <= divisor;
        rem_r  <= '0;
        quo_r  <= '0;
        ovf_r  <= 1'b0;
      end else if (busy_r) begin
        num_r <= {num_r[NW-2:0], 1'b0};
        rem_r <= rem_nxt;
        quo_r <= {quo_r[SW-2:0], ge};
        // any quotient bit above the scale width means saturation
        ovf_r <= ovf_r | quo_r[SW-1];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CW'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // a zero divisor yields all ones, so it saturates here as well
  assign done = done_r;
  assign quot = ovf_r ? '1 : quo_r;

endmodule
`default_nettype wire

@@ hdl/mmc_mul.sv @@
`default_nettype none
module mmc_mul #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [mmc_pkg::DIFF_W-1:0]   diff,
  input  wire logic [FRAC_BITS+1:0]                scale,
  output logic                                     done,
  output logic signed [mmc_pkg::CAL_W-1:0]         cal
);

  localparam int SW = FRAC_BITS + 2;
  localparam int HW = mmc_pkg::DIFF_W + 1;
  localparam int PW = HW + SW;
  localparam int SH = FRAC_BITS - 3;
  localparam int CW = $clog2(SW);

  logic                           busy_r;
  logic                           rnd_r;
  logic                           done_r;
  logic [CW-1:0]                  cnt_r;
  logic signed [HW-1:0]           hi_r;
  logic [SW-1:0]                  lo_r;
  logic signed [mmc_pkg::DIFF_W-1:0] dif_r;
  logic signed [mmc_pkg::CAL_W-1:0]  cal_r;

  logic signed [HW-1:0] add;
  logic signed [PW-1:0] prod;
  logic signed [PW-1:0] rsum;

  // shift-add over the scale bits, lsb first; product shifts into lo_r
  always_comb begin
    add  = lo_r[0] ? (hi_r + {dif_r[mmc_pkg::DIFF_W-1], dif_r}) : hi_r;
    prod = {hi_r, lo_r};
    rsum = prod + (PW'(1) << (SH - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        hi_r   <= '0;
        lo_r   <= scale;
        dif_r  <= diff;
      end else if (busy_r) begin
        {hi_r, lo_r} <= {add[HW-1], add, lo_r[SW-1:1]};
        cnt_r        <= cnt_r + 1'b1;
        if (cnt_r == CW'(SW - 1)) begin
          busy_r <= 1'b0;
          rnd_r  <= 1'b1;
        end
      end else if (rnd_r) begin
        rnd_r  <= 1'b0;
        done_r <= 1'b1;
        // |diff| < 2^17 and scale < 2^(F+2): the rounded value always fits 24 bits
        cal_r  <= rsum[SH+mmc_pkg::CAL_W-1:SH];
      end
    end
  end

  assign done = done_r;
  assign cal  = cal_r;

endmodule
`default_nettype wire

@@ hdl/magnetometer_minmax_calibration.sv @@
// Min/max magnetometer calibration. A start item (kind 0) opens a run that tracks
// per-axis min and max over the next calib_samples good samples; a failed read ends
// the run with status 2 and keeps the old offsets and scales. The last sample of a run
// stores per axis twice the offset (max+min) and a Q2.SCALE_FRAC_BITS scale (mean
// half-range over that axis range, saturated, range_zero set on a flat axis). Outside
// a run each good sample comes back as (raw-offset)*scale in 1/16 counts. Every item
// gives one result. Start, failed and in-run items go straight to the emit state; a
// corrected sample waits on three bit-serial multiplier lanes running in parallel; the
// item that closes a run waits on one restoring divider that forms the three scales
// one bit a cycle in turn. The output register lets a result wait for out_ready while
// the block returns to idle.
`default_nettype none
module magnetometer_minmax_calibration #(
  parameter int SCALE_FRAC_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_ready,
  input  wire logic                                  in_kind,
  input  wire logic signed [mmc_pkg::RAW_W-1:0]      in_raw_x,
  input  wire logic signed [mmc_pkg::RAW_W-1:0]      in_raw_y,
  input  wire logic signed [mmc_pkg::RAW_W-1:0]      in_raw_z,
  input  wire logic                                  in_read_ok,
  output logic                                       out_valid,
  input  wire logic                                  out_ready,
  output logic [1:0]                                 out_status,
  output logic signed [mmc_pkg::CAL_W-1:0]           out_cal_x,
  output logic signed [mmc_pkg::CAL_W-1:0]           out_cal_y,
  output logic signed [mmc_pkg::CAL_W-1:0]           out_cal_z,
  output logic                                       out_range_zero,
  input  wire logic                                  cfg_psel,
  input  wire logic                                  cfg_penable,
  input  wire logic                                  cfg_pwrite,
  input  wire logic [mmc_pkg::CFG_ADDR_W-1:0]        cfg_paddr,
  input  wire logic [mmc_pkg::CFG_DATA_W-1:0]        cfg_pwdata,
  output logic [mmc_pkg::CFG_DATA_W-1:0]             cfg_prdata,
  output logic                                       cfg_pready
);

  localparam int SW = SCALE_FRAC_BITS + 2;
  localparam int NW = mmc_pkg::SUM_W + SCALE_FRAC_BITS;
  localparam int NA = mmc_pkg::NUM_AXES;
  localparam logic [1:0] LAST_AXIS = 2'(NA - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_PREP,
    ST_DIV,
    ST_EMIT
  } state_t;

  state_t                              state_r;
  logic [mmc_pkg::CNT_W-1:0]           calib_samples_r;
  logic signed [mmc_pkg::RAW_W-1:0]    axis_min_r [NA];
  logic signed [mmc_pkg::RAW_W-1:0]    axis_max_r [NA];
  logic [mmc_pkg::CNT_W-1:0]           seen_r;
  logic                                calib_r;
  logic signed [mmc_pkg::OFS_W-1:0]    ofs_r [NA];
  logic [SW-1:0]                       scale_r [NA];
  logic [mmc_pkg::RANGE_W-1:0]         rng_r [NA];
  logic [mmc_pkg::SUM_W-1:0]           sum_r;
  logic [1:0]                          axis_r;
  logic                                div_start_r;
  mmc_pkg::status_t                    res_status_r;
  logic                                res_zero_r;
  logic                                out_valid_r;
  mmc_pkg::status_t                    out_status_r;
  logic signed [mmc_pkg::CAL_W-1:0]    out_cal_r [NA];
  logic                                out_zero_r;

  logic signed [mmc_pkg::RAW_W-1:0]    raw [NA];
  logic signed [mmc_pkg::DIFF_W-1:0]   diff [NA];
  logic signed [mmc_pkg::OFS_W-1:0]    span [NA];
  logic [mmc_pkg::RANGE_W-1:0]         rng [NA];
  logic signed [mmc_pkg::OFS_W-1:0]    ofs_new [NA];
  logic [mmc_pkg::SUM_W-1:0]           sum_new;
  logic                                any_zero;
  logic [mmc_pkg::CNT_W-1:0]           seen_nxt;
  logic                                run_end;
  logic                                accept;
  logic                                mul_start;
  logic                                cfg_wr;
  logic [mmc_pkg::SUM_W-1:0]           rng3;
  logic [NW-1:0]                       div_numer;
  logic [mmc_pkg::DVSR_W-1:0]          div_dvsr;
  logic                                div_done;
  logic [SW-1:0]                       div_quot;
  logic [NA-1:0]                       lane_done;
  logic signed [mmc_pkg::CAL_W-1:0]    lane_cal [NA];

  assign raw[0] = in_raw_x;
  assign raw[1] = in_raw_y;
  assign raw[2] = in_raw_z;

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign mul_start = accept && (in_kind == mmc_pkg::KIND_SAMPLE) && in_read_ok && !calib_r;
  assign seen_nxt  = seen_r + 1'b1;
  // a zero sample count ends the run after one sample
  assign run_end   = (seen_nxt >= calib_samples_r) || (seen_nxt == '0);

  always_comb begin
    sum_new  = '0;
    any_zero = 1'b0;
    for (int i = 0; i < NA; i++) begin
      diff[i]    = {raw[i][mmc_pkg::RAW_W-1], raw[i], 1'b0}
                   - {ofs_r[i][mmc_pkg::OFS_W-1], ofs_r[i]};
      span[i]    = {axis_max_r[i][mmc_pkg::RAW_W-1], axis_max_r[i]}
                   - {axis_min_r[i][mmc_pkg::RAW_W-1], axis_min_r[i]};
      rng[i]     = span[i][mmc_pkg::OFS_W-1] ? '0 : span[i][mmc_pkg::RANGE_W-1:0];
      ofs_new[i] = {axis_max_r[i][mmc_pkg::RAW_W-1], axis_max_r[i]}
                   + {axis_min_r[i][mmc_pkg::RAW_W-1], axis_min_r[i]};
      sum_new    = sum_new + mmc_pkg::SUM_W'(rng[i]);
      any_zero   = any_zero | (rng[i] == '0);
    end
  end

  // scale = (sum << F + 3r) / 6r, rounding half up
  assign rng3      = {1'b0, rng_r[axis_r], 1'b0} + mmc_pkg::SUM_W'(rng_r[axis_r]);
  assign div_numer = {sum_r, SCALE_FRAC_BITS'(0)} + NW'(rng3);
  assign div_dvsr  = {rng3, 1'b0};

  mmc_div #(
    .FRAC_BITS(SCALE_FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start_r),
    .numer   (div_numer),
    .divisor (div_dvsr),
    .done    (div_done),
    .quot    (div_quot)
  );

  for (genvar g = 0; g < NA; g++) begin : g_lane
    mmc_mul #(
      .FRAC_BITS(SCALE_FRAC_BITS)
    ) u_mul (
      .clk   (clk),
      .rst_n (rst_n),
      .start (mul_start),
      .diff  (diff[g]),
      .scale (scale_r[g]),
      .done  (lane_done[g]),
      .cal   (lane_cal[g])
    );
  end

  assign cfg_wr = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                  && (cfg_paddr[2] == mmc_pkg::REG_CALIB_SAMPLES);
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == mmc_pkg::REG_CALIB_SAMPLES)
                      ? mmc_pkg::CFG_DATA_W'(calib_samples_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_IDLE;
      calib_samples_r <= mmc_pkg::CALIB_SAMPLES_RST;
      seen_r          <= '0;
      calib_r         <= 1'b0;
      div_start_r     <= 1'b0;
      out_valid_r     <= 1'b0;
      for (int i = 0; i < NA; i++) begin
        axis_min_r[i] <= mmc_pkg::MIN_RST;
        axis_max_r[i] <= mmc_pkg::MAX_RST;
        ofs_r[i]      <= '0;
        scale_r[i]    <= SW'(1) << SCALE_FRAC_BITS;
      end
    end else begin
      div_start_r <= 1'b0;
      if (cfg_wr) begin
        calib_samples_r <= cfg_pwdata[mmc_pkg::CNT_W-1:0];
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            res_zero_r <= 1'b0;
            if (in_kind == mmc_pkg::KIND_START) begin
              for (int i = 0; i < NA; i++) begin
                axis_min_r[i] <= mmc_pkg::MIN_RST;
                axis_max_r[i] <= mmc_pkg::MAX_RST;
              end
              seen_r       <= '0;
              calib_r      <= 1'b1;
              res_status_r <= mmc_pkg::STAT_CALIB;
              state_r      <= ST_EMIT;
            end else if (!in_read_ok) begin
              seen_r       <= '0;
              calib_r      <= 1'b0;
              res_status_r <= mmc_pkg::STAT_FAIL;
              state_r      <= ST_EMIT;
            end else if (calib_r) begin
              for (int i = 0; i < NA; i++) begin
                if (raw[i] < axis_min_r[i]) axis_min_r[i] <= raw[i];
                if (raw[i] > axis_max_r[i]) axis_max_r[i] <= raw[i];
              end
              if (run_end) begin
                seen_r  <= '0;
                calib_r <= 1'b0;
                state_r <= ST_PREP;
              end else begin
                seen_r       <= seen_nxt;
                res_status_r <= mmc_pkg::STAT_CALIB;
                state_r      <= ST_EMIT;
              end
            end else begin
              state_r <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          if (lane_done[0]) begin
            res_status_r <= mmc_pkg::STAT_CORR;
            state_r      <= ST_EMIT;
          end
        end
        ST_PREP: begin
          for (int i = 0; i < NA; i++) begin
            rng_r[i] <= rng[i];
            ofs_r[i] <= ofs_new[i];
          end
          sum_r       <= sum_new;
          res_zero_r  <= any_zero;
          axis_r      <= '0;
          div_start_r <= 1'b1;
          state_r     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            scale_r[axis_r] <= div_quot;
            if (axis_r == LAST_AXIS) begin
              res_status_r <= mmc_pkg::STAT_DONE;
              state_r      <= ST_EMIT;
            end else begin
              axis_r      <= axis_r + 1'b1;
              div_start_r <= 1'b1;
            end
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r  <= 1'b1;
            out_status_r <= res_status_r;
            out_zero_r   <= res_zero_r;
            for (int i = 0; i < NA; i++) begin
              out_cal_r[i] <= (res_status_r == mmc_pkg::STAT_CORR) ? lane_cal[i] : '0;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_cal_x      = out_cal_r[0];
  assign out_cal_y      = out_cal_r[1];
  assign out_cal_z      = out_cal_r[2];
  assign out_range_zero = out_zero_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("block stayed idle after taking an item");

  a_lanes_in_step: assert property (@(posedge clk) disable iff (!rst_n)
    lane_done[0] == lane_done[1] && lane_done[1] == lane_done[2])
    else $error("multiplier lanes out of step");

  a_cal_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != mmc_pkg::STAT_CORR
      |-> out_cal_r[0] == '0 && out_cal_r[1] == '0 && out_cal_r[2] == '0)
    else $error("nonzero corrected value on a status result");

  a_zero_flag_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_zero_r |-> out_status_r == mmc_pkg::STAT_DONE)
    else $error("range_zero outside a run end result");

  a_div_axis: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV && (axis_r == 2'd0 || axis_r == 2'd1 || axis_r == LAST_AXIS))
    else $error("divider finished outside the scale pass");

endmodule
`default_nettype wire
